@@ rtl/core/dcss_pkg.sv @@
// ----------------------------------------------------------------------------
// dcss_pkg: shared definitions for the DC motor soft-start controller
// Command codes, register indexes and fixed limits of the speed ramp,
// the idle counter and the headlight timeout.
// ----------------------------------------------------------------------------
package dcss_pkg;

    localparam int unsigned SpeedW   = 8;
    localparam int unsigned IdleW    = 22;
    localparam int unsigned TimeoutW = 12;
    localparam int unsigned DataW    = 32;
    localparam int unsigned AddrW    = 5;

    localparam logic [SpeedW-1:0] SPEED_MAX = 8'd254;
    localparam logic [IdleW-1:0]  IDLE_MAX  = 22'h3F_FFFF;
    localparam logic [IdleW-1:0]  MS_PER_S  = 22'd1000;

    // drive command codes
    typedef enum logic [1:0] {
        CMD_FORWARD  = 2'd0,
        CMD_BACKWARD = 2'd1,
        CMD_COAST    = 2'd2,
        CMD_BRAKE    = 2'd3
    } t_cmd;

    // input item kind
    typedef enum logic {
        FUNC_DRIVE = 1'b0,
        FUNC_TICK  = 1'b1
    } t_func;

    // headlight modes
    typedef enum logic [1:0] {
        HL_OFF    = 2'd0,
        HL_ON     = 2'd1,
        HL_AUTO   = 2'd2,
        HL_UNUSED = 2'd3
    } t_hl_mode;

    // configuration register indexes (word address)
    typedef enum logic [2:0] {
        REG_DRIVER_TYPE      = 3'd0,
        REG_HEADLIGHT_PRES   = 3'd1,
        REG_BRAKE_LIGHT_PRES = 3'd2,
        REG_HEADLIGHT_MODE   = 3'd3,
        REG_IDLE_TIMEOUT     = 3'd4
    } t_reg_idx;

    // driver types
    localparam logic DRV_BRIDGE = 1'b0;
    localparam logic DRV_PINS   = 1'b1;

endpackage

@@ rtl/core/dc_motor_soft_start_controller.sv @@
// A beat accepted at the input passes through the input register, then the state
// and result registers, before its result shows.
// One beat per cycle while the result channel is not stalled.
// A stalled result holds the input register; ready drops only when both are full.
// Reset (synchronous, active low) clears speed, direction, idle counter, lights,
// driver levels, configuration and both valid flags.
// ----------------------------------------------------------------------------
// dc_motor_soft_start_controller: soft-start ramp and driver outputs
// Ramps motor speed per drive command, drives a bridge or pin-plus-duty
// driver, controls headlight and brake light, and counts idle milliseconds.
// ----------------------------------------------------------------------------
module dc_motor_soft_start_controller
    import dcss_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    // configuration port
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [AddrW-1:0]    paddr,
    input  logic [DataW-1:0]    pwdata,
    output logic [DataW-1:0]    prdata,
    output logic                pready,
    // input channel
    input  logic                i_valid,
    output logic                o_ready,
    input  logic                i_func,
    input  logic [1:0]          i_direction_cmd,
    input  logic [SpeedW-1:0]   i_target_duty,
    input  logic [SpeedW-1:0]   i_ramp_step,
    // result channel
    output logic                o_valid,
    input  logic                i_ready,
    output logic [SpeedW-1:0]   o_bridge_a,
    output logic [SpeedW-1:0]   o_bridge_b,
    output logic                o_dir_pin_a,
    output logic                o_dir_pin_b,
    output logic [SpeedW-1:0]   o_duty_out,
    output logic                o_headlight_lit,
    output logic                o_brake_lit,
    output logic [SpeedW-1:0]   o_speed_now,
    output logic                o_direction_now
);

    // configuration registers
    logic                r_cfg_driver_type;
    logic                r_cfg_hl_present;
    logic                r_cfg_bl_present;
    t_hl_mode            r_cfg_hl_mode;
    logic [TimeoutW-1:0] r_cfg_timeout_s;
    logic [IdleW-1:0]    r_cfg_timeout_ms;

    // input register
    logic                r_in_valid;
    t_func               r_func;
    t_cmd                r_cmd;
    logic [SpeedW-1:0]   r_target;
    logic [SpeedW-1:0]   r_step;

    // state, which also forms the result register
    logic                r_out_valid;
    logic [SpeedW-1:0]   r_speed,     n_speed;
    logic                r_direction, n_direction;
    logic [IdleW-1:0]    r_idle_ms,   n_idle_ms;
    logic                r_headlight, n_headlight;
    logic                r_brake,     n_brake;
    logic [SpeedW-1:0]   r_bridge_a,  n_bridge_a;
    logic [SpeedW-1:0]   r_bridge_b,  n_bridge_b;
    logic                r_pin_a,     n_pin_a;
    logic                r_pin_b,     n_pin_b;
    logic [SpeedW-1:0]   r_held_duty, n_held_duty;

    logic                cfg_wr;
    logic                advance;
    logic [SpeedW-1:0]   speed_dec;
    logic [SpeedW-1:0]   tgt_eff;
    logic [SpeedW:0]     sum_up;
    logic [SpeedW:0]     sum_dn;
    logic [SpeedW-1:0]   ramp;

    // --- configuration port ---
    assign pready = 1'b1;
    assign cfg_wr = psel & penable & pwrite & pready;

    // latch register writes; keep the timeout in milliseconds as well
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_driver_type <= DRV_BRIDGE;
            r_cfg_hl_present  <= 1'b0;
            r_cfg_bl_present  <= 1'b0;
            r_cfg_hl_mode     <= HL_OFF;
            r_cfg_timeout_s   <= '0;
            r_cfg_timeout_ms  <= '0;
        end else if (cfg_wr) begin
            case (t_reg_idx'(paddr[4:2]))
                REG_DRIVER_TYPE:      r_cfg_driver_type <= pwdata[0];
                REG_HEADLIGHT_PRES:   r_cfg_hl_present  <= pwdata[0];
                REG_BRAKE_LIGHT_PRES: r_cfg_bl_present  <= pwdata[0];
                REG_HEADLIGHT_MODE:   r_cfg_hl_mode     <= t_hl_mode'(pwdata[1:0]);
                REG_IDLE_TIMEOUT: begin
                    r_cfg_timeout_s  <= pwdata[TimeoutW-1:0];
                    r_cfg_timeout_ms <= IdleW'(pwdata[TimeoutW-1:0]) * MS_PER_S;
                end
                default: ;
            endcase
        end
    end

    // read back
    always_comb begin
        prdata = '0;
        case (t_reg_idx'(paddr[4:2]))
            REG_DRIVER_TYPE:      prdata[0]          = r_cfg_driver_type;
            REG_HEADLIGHT_PRES:   prdata[0]          = r_cfg_hl_present;
            REG_BRAKE_LIGHT_PRES: prdata[0]          = r_cfg_bl_present;
            REG_HEADLIGHT_MODE:   prdata[1:0]        = r_cfg_hl_mode;
            REG_IDLE_TIMEOUT:     prdata[TimeoutW-1:0] = r_cfg_timeout_s;
            default:              prdata             = '0;
        endcase
    end

    // --- handshake ---
    // advance the held beat once the result slot is free or being emptied
    assign advance = r_in_valid & (~r_out_valid | i_ready);
    assign o_ready = ~r_in_valid | advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_ready) begin
            r_in_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_func   <= t_func'(i_func);
            r_cmd    <= t_cmd'(i_direction_cmd);
            r_target <= i_target_duty;
            r_step   <= i_ramp_step;
        end
    end

    // --- ramp arithmetic ---
    always_comb begin
        n_direction = r_direction;
        if (r_speed == '0 && (r_cmd == CMD_FORWARD || r_cmd == CMD_BACKWARD)) begin
            n_direction = r_cmd[0];
        end

        // head back toward zero on a direction change, coast or brake
        speed_dec = (r_speed != '0) ? (r_speed - SpeedW'(1)) : '0;
        tgt_eff   = (r_cmd != t_cmd'({1'b0, n_direction})) ? speed_dec : r_target;

        sum_up = {1'b0, r_speed} + {1'b0, r_step};
        sum_dn = {1'b0, r_speed} - {1'b0, r_step};

        // step equal to target jumps; otherwise step and clamp to 0..254
        if (r_step == tgt_eff) begin
            ramp = (tgt_eff > SPEED_MAX) ? SPEED_MAX : tgt_eff;
        end else if (r_speed < tgt_eff) begin
            ramp = (sum_up > {1'b0, SPEED_MAX}) ? SPEED_MAX : sum_up[SpeedW-1:0];
        end else if (r_speed > tgt_eff) begin
            ramp = sum_dn[SpeedW] ? '0 : sum_dn[SpeedW-1:0];
        end else begin
            ramp = r_speed;
        end
    end

    // --- next state ---
    always_comb begin
        n_speed     = r_speed;
        n_idle_ms   = r_idle_ms;
        n_headlight = r_headlight;
        n_brake     = r_brake;
        n_bridge_a  = r_bridge_a;
        n_bridge_b  = r_bridge_b;
        n_pin_a     = r_pin_a;
        n_pin_b     = r_pin_b;
        n_held_duty = r_held_duty;

        if (r_func == FUNC_TICK) begin
            // count idle milliseconds, saturating
            if (r_idle_ms != IDLE_MAX) begin
                n_idle_ms = r_idle_ms + IdleW'(1);
            end
        end else begin
            // headlight, judged on the speed before the ramp
            if (r_cfg_hl_present) begin
                case (r_cfg_hl_mode)
                    HL_ON:  n_headlight = 1'b1;
                    HL_OFF: n_headlight = 1'b0;
                    HL_AUTO: begin
                        if (r_speed != '0) begin
                            n_idle_ms   = '0;
                            n_headlight = 1'b1;
                        end else if (r_idle_ms > r_cfg_timeout_ms) begin
                            n_headlight = 1'b0;
                        end
                    end
                    default: ;
                endcase
            end

            n_speed = ramp;

            // drive only the configured driver's outputs
            if (r_cfg_driver_type == DRV_BRIDGE) begin
                case (r_cmd)
                    CMD_COAST: begin
                        n_bridge_a = '0;
                        n_bridge_b = '0;
                    end
                    CMD_BRAKE: begin
                        n_bridge_a = SPEED_MAX;
                        n_bridge_b = SPEED_MAX;
                    end
                    default: begin
                        n_bridge_a = n_direction ? ramp : '0;
                        n_bridge_b = n_direction ? '0 : ramp;
                    end
                endcase
            end else begin
                case (r_cmd)
                    CMD_COAST: begin
                        n_pin_a = 1'b0;
                        n_pin_b = 1'b0;
                    end
                    CMD_BRAKE: begin
                        n_pin_a = 1'b1;
                        n_pin_b = 1'b1;
                    end
                    default: begin
                        n_pin_a     = n_direction;
                        n_pin_b     = ~n_direction;
                        n_held_duty = ramp;
                    end
                endcase
            end

            // brake light: slowing down or braking
            if (r_cfg_bl_present) begin
                n_brake = (ramp > tgt_eff) || (r_cmd == CMD_BRAKE);
            end
        end
    end

    // --- state and result registers ---
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_speed     <= '0;
            r_direction <= 1'b0;
            r_idle_ms   <= '0;
            r_headlight <= 1'b0;
            r_brake     <= 1'b0;
            r_bridge_a  <= '0;
            r_bridge_b  <= '0;
            r_pin_a     <= 1'b0;
            r_pin_b     <= 1'b0;
            r_held_duty <= '0;
        end else begin
            if (advance) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
            if (advance) begin
                r_speed     <= n_speed;
                r_direction <= (r_func == FUNC_DRIVE) ? n_direction : r_direction;
                r_idle_ms   <= n_idle_ms;
                r_headlight <= n_headlight;
                r_brake     <= n_brake;
                r_bridge_a  <= n_bridge_a;
                r_bridge_b  <= n_bridge_b;
                r_pin_a     <= n_pin_a;
                r_pin_b     <= n_pin_b;
                r_held_duty <= n_held_duty;
            end
        end
    end

    // --- result beat ---
    assign o_valid         = r_out_valid;
    assign o_bridge_a      = r_bridge_a;
    assign o_bridge_b      = r_bridge_b;
    assign o_dir_pin_a     = r_pin_a;
    assign o_dir_pin_b     = r_pin_b;
    assign o_duty_out      = r_held_duty;
    assign o_headlight_lit = r_cfg_hl_present & r_headlight;
    assign o_brake_lit     = r_cfg_bl_present & r_brake;
    assign o_speed_now     = r_speed;
    assign o_direction_now = r_direction;

endmodule

@@ rtl/core/dcss_checker.sv @@
// ----------------------------------------------------------------------------
// dcss_checker: port-level checks for the soft-start controller
// Watches the result channel and the driver levels over time.
// ----------------------------------------------------------------------------
module dcss_checker
    import dcss_pkg::*;
(
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              o_ready,
    input logic              o_valid,
    input logic              i_ready,
    input logic [SpeedW-1:0] o_bridge_a,
    input logic [SpeedW-1:0] o_bridge_b,
    input logic [SpeedW-1:0] o_duty_out,
    input logic [SpeedW-1:0] o_speed_now
);

    // hold a stalled result beat
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_speed_now)
            && $stable(o_bridge_a) && $stable(o_bridge_b) && $stable(o_duty_out))
        else $error("result beat changed while stalled");

    // an empty result slot never blocks the input
    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_valid |-> o_ready)
        else $error("input blocked with result slot empty");

    // speed and duties stay within the clamp
    a_clamp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_speed_now <= SPEED_MAX && o_bridge_a <= SPEED_MAX
            && o_bridge_b <= SPEED_MAX && o_duty_out <= SPEED_MAX)
        else $error("level beyond clamp");

    // both bridge inputs driven only when braking
    a_bridge_pair: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_bridge_a != '0 && o_bridge_b != '0
            |-> o_bridge_a == SPEED_MAX && o_bridge_b == SPEED_MAX)
        else $error("both bridge inputs driven outside brake");

endmodule

bind dc_motor_soft_start_controller dcss_checker u_dcss_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_ready     (o_ready),
    .o_valid     (o_valid),
    .i_ready     (i_ready),
    .o_bridge_a  (o_bridge_a),
    .o_bridge_b  (o_bridge_b),
    .o_duty_out  (o_duty_out),
    .o_speed_now (o_speed_now)
);
